@@ design/klst_pkg.sv @@
// klst_pkg: shared types, codes and color helper for the keyed light slot table.
// No dependencies; every other design file refers to it by scoped names.
package klst_pkg;

  // Item function codes
  localparam logic [1:0] FUNC_NEW  = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_LIFETIME = 2'd0;
  localparam logic [1:0] CFG_DECAY    = 2'd1;

  localparam logic [15:0] LIFETIME_RST = 16'd102;
  localparam logic [15:0] RADIUS_ONE   = 16'd256;  // 1.0 in Q8.8
  localparam int unsigned LOSS_W       = 22;       // (16x16 product) >> 10

  localparam logic [9:0] COL_BRIGHT = 10'd400;
  localparam logic [9:0] COL_DIM    = 10'd200;
  localparam logic [9:0] COL_TINT   = 10'd20;
  localparam logic [9:0] COL_EXTRA  = 10'd180;

  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        light_key;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [3:0]         effect_flags;
    logic [31:0]        now;
    logic [15:0]        frame_time;
    logic [4:0]         slot_sel;
  } in_t;

  typedef struct packed {
    logic [4:0]         slot_index;
    logic [15:0]        out_key;
    logic [15:0]        out_radius;
    logic [31:0]        out_expiry;
    logic [9:0]         out_red;
    logic [9:0]         out_green;
    logic [9:0]         out_blue;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
  } out_t;

  // One light slot, as held by a cell of the ring
  typedef struct packed {
    logic [15:0]        key;
    logic [31:0]        expiry;
    logic [15:0]        radius;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [9:0]         red;
    logic [9:0]         green;
    logic [9:0]         blue;
  } slot_t;

  typedef struct packed {
    logic [9:0] red;
    logic [9:0] green;
    logic [9:0] blue;
  } color_t;

  // Ring control from the sequencer to the cells
  typedef struct packed {
    logic shift;   // rotate the ring by one cell
    logic wr_en;   // load the addressed cell
  } ring_ctl_t;

  // Red or blue replaces the bright/dim white with a dim tinted color
  function automatic color_t fx_color(input logic [3:0] fx);
    color_t c;
    c = '0;
    if (fx[0]) begin
      c.red   = c.red + COL_BRIGHT;
      c.green = c.green + COL_BRIGHT;
      c.blue  = c.blue + COL_BRIGHT;
    end
    if (fx[1]) begin
      c.red   = c.red + COL_DIM;
      c.green = c.green + COL_DIM;
      c.blue  = c.blue + COL_DIM;
    end
    if (fx[2] || fx[3]) begin
      c.red   = COL_TINT;
      c.green = COL_TINT;
      c.blue  = COL_TINT;
      if (fx[2]) c.red = c.red + COL_EXTRA;
      if (fx[3]) c.blue = c.blue + COL_EXTRA;
    end
    return c;
  endfunction

endpackage

@@ design/klst_cell.sv @@
// klst_cell: one slot of the light ring; loads from its neighbor or a direct write.
// Depends on klst_pkg.
module klst_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  klst_pkg::ring_ctl_t ctl,
  input  logic              sel,       // this cell is the write target
  input  klst_pkg::slot_t   nb_slot,   // from the next cell of the ring
  input  klst_pkg::slot_t   wr_slot,
  output klst_pkg::slot_t   slot
);

  klst_pkg::slot_t slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (ctl.wr_en && sel) begin
      slot_r <= wr_slot;
    end else if (ctl.shift) begin
      slot_r <= nb_slot;
    end
  end

  assign slot = slot_r;

endmodule

@@ design/klst_seq.sv @@
// klst_seq: item sequencer at the head of the slot ring; slot search, decay,
// read capture and the output register. Depends on klst_pkg.
module klst_seq #(
  parameter int unsigned NUM_SLOTS = 32,
  localparam int unsigned IDX_W    = $clog2(NUM_SLOTS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  klst_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output klst_pkg::out_t      out_data,
  input  logic [15:0]         lifetime,
  input  logic [15:0]         decay,
  input  klst_pkg::slot_t     head_slot,  // slot currently in cell 0
  output klst_pkg::slot_t     ring_slot,  // value rotated into the last cell
  output klst_pkg::ring_ctl_t ctl,
  output logic [IDX_W-1:0]    wr_idx,
  output klst_pkg::slot_t     wr_slot
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SWEEP  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_SLOTS - 1);

  logic [1:0]                   state_r, state_nxt;
  logic [IDX_W-1:0]             step_r;
  klst_pkg::in_t                item_r;
  logic [klst_pkg::LOSS_W-1:0]  loss_r;
  logic                         key_hit_r, free_hit_r;
  logic [IDX_W-1:0]             key_idx_r, free_idx_r;
  klst_pkg::slot_t              rd_slot_r;
  logic                         out_valid_r;
  klst_pkg::out_t               out_data_r;

  logic            accept, out_free, sel_ok, key_eq, is_free, rd_hit;
  logic [32:0]     exp_sum;
  logic [31:0]     exp_sat;
  logic [15:0]     rad_dec;
  klst_pkg::color_t color;
  klst_pkg::out_t  result;
  logic [IDX_W-1:0] pick;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign sel_ok   = 32'(in_data.slot_sel) < 32'(NUM_SLOTS);

  // Head cell compares
  assign key_eq  = (item_r.light_key != '0) && (head_slot.key == item_r.light_key);
  assign is_free = (head_slot.expiry < item_r.now) || (head_slot.radius == '0);
  assign rd_hit  = 32'(step_r) == 32'(item_r.slot_sel);

  // Decay of the slot passing the head
  always_comb begin
    if (head_slot.radius == '0 || !(item_r.now < head_slot.expiry) ||
        loss_r >= klst_pkg::LOSS_W'(head_slot.radius)) begin
      rad_dec = '0;
    end else begin
      rad_dec = head_slot.radius - loss_r[15:0];
    end
  end

  always_comb begin
    ring_slot = head_slot;
    if (item_r.func == klst_pkg::FUNC_TICK) ring_slot.radius = rad_dec;
  end

  // New light contents
  assign exp_sum = {1'b0, item_r.now} + {17'd0, lifetime};
  assign exp_sat = exp_sum[32] ? '1 : exp_sum[31:0];
  assign color   = klst_pkg::fx_color(item_r.effect_flags);
  assign pick    = key_hit_r ? key_idx_r : (free_hit_r ? free_idx_r : '0);

  always_comb begin
    wr_slot        = '0;
    wr_slot.key    = item_r.light_key;
    wr_slot.expiry = exp_sat;
    wr_slot.radius = klst_pkg::RADIUS_ONE;
    wr_slot.x      = item_r.pos_x;
    wr_slot.y      = item_r.pos_y;
    wr_slot.z      = item_r.pos_z;
    wr_slot.red    = color.red;
    wr_slot.green  = color.green;
    wr_slot.blue   = color.blue;
  end

  always_comb begin
    result = '0;
    unique case (item_r.func)
      klst_pkg::FUNC_NEW: begin
        result.slot_index = 5'(pick);
        result.out_key    = wr_slot.key;
        result.out_radius = wr_slot.radius;
        result.out_expiry = wr_slot.expiry;
        result.out_red    = wr_slot.red;
        result.out_green  = wr_slot.green;
        result.out_blue   = wr_slot.blue;
        result.out_x      = wr_slot.x;
        result.out_y      = wr_slot.y;
        result.out_z      = wr_slot.z;
      end
      klst_pkg::FUNC_READ: begin
        result.slot_index = item_r.slot_sel;
        if (32'(item_r.slot_sel) < 32'(NUM_SLOTS)) begin
          result.out_key    = rd_slot_r.key;
          result.out_radius = rd_slot_r.radius;
          result.out_expiry = rd_slot_r.expiry;
          result.out_red    = rd_slot_r.red;
          result.out_green  = rd_slot_r.green;
          result.out_blue   = rd_slot_r.blue;
          result.out_x      = rd_slot_r.x;
          result.out_y      = rd_slot_r.y;
          result.out_z      = rd_slot_r.z;
        end
      end
      default: result = '0;  // tick and unused code
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.func == klst_pkg::FUNC_NEW || in_data.func == klst_pkg::FUNC_TICK ||
              (in_data.func == klst_pkg::FUNC_READ && sel_ok)) begin
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SWEEP: begin
        ctl.shift = 1'b1;
        if (step_r == LAST) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          ctl.wr_en = (item_r.func == klst_pkg::FUNC_NEW);
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign wr_idx = pick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      key_hit_r   <= 1'b0;
      free_hit_r  <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        step_r     <= '0;
        key_hit_r  <= 1'b0;
        free_hit_r <= 1'b0;
      end else if (state_r == ST_SWEEP) begin
        step_r <= step_r + 1'b1;
        if (item_r.func == klst_pkg::FUNC_NEW) begin
          if (!key_hit_r && key_eq) key_hit_r <= 1'b1;
          if (!free_hit_r && is_free) free_hit_r <= 1'b1;
        end
      end
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      loss_r <= klst_pkg::LOSS_W'((32'(in_data.frame_time) * 32'(decay)) >> 10);
    end
    if (state_r == ST_SWEEP) begin
      if (!key_hit_r && key_eq) key_idx_r <= step_r;
      if (!free_hit_r && is_free) free_idx_r <= step_r;
      if (rd_hit) rd_slot_r <= head_slot;
    end
    if (state_r == ST_FINISH && out_free) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("accepted item left the sequencer idle");

  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && step_r == LAST) |=> state_r == ST_FINISH)
    else $error("ring sweep did not end after the last slot");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result raised outside the finish step");

  a_key_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    key_hit_r |-> item_r.light_key != '0)
    else $error("key match recorded for a zero key");

endmodule

@@ design/keyed_light_slot_table.sv @@
// keyed_light_slot_table: top level; configuration registers, the ring of slot
// cells and the head sequencer. Depends on klst_pkg, klst_cell and klst_seq.
//
// The slot store is a ring of NUM_SLOTS cells that rotates by one cell per
// clock while an item sweeps it. Every slot passes the single compare/decay
// point at cell 0. New-light, tick and in-range read items run a sweep that
// rotates every slot once round the ring, back to its own cell, and then a
// finish step that loads the result register and, for a new light, writes the
// chosen cell directly. The next transfer in is taken in the idle state after
// that. A read beyond the table or an unused function code skips the sweep and
// goes straight to the finish step. One item is in work at a time, and
// in_stall is high from the transfer until the result is loaded. A finished
// result waits in the output register without blocking the next transfer in.
// That next item's load cycle, and with it in_stall, waits while the earlier
// result is still held. The table clears to zero at reset, all cells at once,
// so no clearing pass is needed. Configuration must be written through
// cfg_we/cfg_index/cfg_wdata while no item is in work; the block does not
// enforce it. Index 0 is the light lifetime (1/1024 s) and index 1 the decay
// rate (Q8.8 per second); other indexes are ignored.
module keyed_light_slot_table #(
  parameter int unsigned NUM_SLOTS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  klst_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output klst_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_wdata
);

  localparam int unsigned IDX_W = $clog2(NUM_SLOTS);

  logic [15:0] lifetime_r, decay_r;

  klst_pkg::slot_t     slots [NUM_SLOTS];
  klst_pkg::slot_t     ring_slot, wr_slot;
  klst_pkg::ring_ctl_t ctl;
  logic [IDX_W-1:0]    wr_idx;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= klst_pkg::LIFETIME_RST;
      decay_r    <= '0;
    end else if (cfg_we) begin
      if (cfg_index == klst_pkg::CFG_LIFETIME) lifetime_r <= cfg_wdata;
      if (cfg_index == klst_pkg::CFG_DECAY) decay_r <= cfg_wdata;
    end
  end

  // Ring: each cell takes its successor; the last takes the head's output
  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    klst_pkg::slot_t nb;
    if (k == NUM_SLOTS - 1) begin : g_tail
      assign nb = ring_slot;
    end else begin : g_mid
      assign nb = slots[k+1];
    end
    klst_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .sel     (wr_idx == IDX_W'(k)),
      .nb_slot (nb),
      .wr_slot (wr_slot),
      .slot    (slots[k])
    );
  end

  klst_seq #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .lifetime  (lifetime_r),
    .decay     (decay_r),
    .head_slot (slots[0]),
    .ring_slot (ring_slot),
    .ctl       (ctl),
    .wr_idx    (wr_idx),
    .wr_slot   (wr_slot)
  );

endmodule
